// ----- design/dipid_pkg.sv -----
package dipid_pkg;

  // fixed-point format and limits
  localparam int unsigned PWM_LIMIT      = 1000;
  localparam int unsigned TARGET_LIMIT   = 1000;
  localparam int unsigned GAIN_FRAC_BITS = 8;

  // field widths
  localparam int unsigned GAIN_W   = 16;
  localparam int unsigned TARGET_W = 11;
  localparam int unsigned COUNT_W  = 16;
  localparam int unsigned DUTY_W   = 10;

  // datapath widths
  localparam int unsigned ERR_W  = 18;                  // e and e - e1
  localparam int unsigned D2_W   = ERR_W + 1;           // e - 2*e1 + e2
  localparam int unsigned PROD_W = GAIN_W + 1 + D2_W;   // signed product
  localparam int unsigned SUM_W  = PROD_W + 3;          // acc plus three products
  localparam int unsigned ACC_W  = 20;

  localparam int unsigned NUM_WHEELS = 2;

  localparam int unsigned CFG_IDX_W  = 3;
  localparam int unsigned CFG_DATA_W = 16;

  localparam logic signed [ACC_W-1:0] ACC_LIMIT =
    ACC_W'(PWM_LIMIT << GAIN_FRAC_BITS);
  localparam logic signed [TARGET_W-1:0] TGT_MAX = TARGET_W'(TARGET_LIMIT);

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_PROP_GAIN    = 3'd0,
    CFG_INTEG_GAIN   = 3'd1,
    CFG_DERIV_GAIN   = 3'd2,
    CFG_LEFT_TARGET  = 3'd3,
    CFG_RIGHT_TARGET = 3'd4
  } cfg_idx_e;

  // saturate a raw target write to +/- TARGET_LIMIT
  function automatic logic signed [TARGET_W-1:0] clamp_target(
    input logic [TARGET_W-1:0] raw
  );
    logic signed [TARGET_W-1:0] t;
    t = signed'(raw);
    if (t > TGT_MAX) begin
      clamp_target = TGT_MAX;
    end else if (t < -TGT_MAX) begin
      clamp_target = -TGT_MAX;
    end else begin
      clamp_target = t;
    end
  endfunction

endpackage

// ----- design/dual_incremental_pid_hbridge_drive.sv -----
// path: an input transfer reaches the master side through the input register
//   and the result register; the pid arithmetic for both wheels sits
//   combinational between the two
// throughput: one item per cycle; both registers advance together and
//   stall only while a finished result waits on m_axis_tready
// reset (rst_ni low, async): nothing in flight, errors and accumulators zero,
//   gains 0.5 / ~0.1 / 0 (Q8.8), both targets zero
module dual_incremental_pid_hbridge_drive
  import dipid_pkg::*;
(
  input  logic                  clk_i,
  input  logic                  rst_ni,

  // register write channel
  input  logic                  cfg_valid_i,
  output logic                  cfg_ready_o,
  input  logic [CFG_IDX_W-1:0]  cfg_index_i,
  input  logic [CFG_DATA_W-1:0] cfg_data_i,

  // encoder counts in
  input  logic                  s_axis_tvalid,
  output logic                  s_axis_tready,
  input  logic [31:0]           s_axis_tdata,   // left_count[15:0], right_count[31:16]

  // pwm compare values out
  output logic                  m_axis_tvalid,
  input  logic                  m_axis_tready,
  output logic [39:0]           m_axis_tdata    // left_forward_duty[9:0],
                                                // left_reverse_duty[19:10],
                                                // right_forward_duty[29:20],
                                                // right_reverse_duty[39:30]
);

  // ---------------------------------------------------------------------------
  // configuration registers
  // ---------------------------------------------------------------------------
  logic        [GAIN_W-1:0]   prop_gain_q, integ_gain_q, deriv_gain_q;
  logic signed [TARGET_W-1:0] target_q [NUM_WHEELS];

  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      prop_gain_q  <= GAIN_W'(128);
      integ_gain_q <= GAIN_W'(26);
      deriv_gain_q <= '0;
      target_q[0]  <= '0;
      target_q[1]  <= '0;
    end else if (cfg_valid_i) begin
      unique case (cfg_index_i)
        CFG_PROP_GAIN:    prop_gain_q  <= cfg_data_i;
        CFG_INTEG_GAIN:   integ_gain_q <= cfg_data_i;
        CFG_DERIV_GAIN:   deriv_gain_q <= cfg_data_i;
        CFG_LEFT_TARGET:  target_q[0]  <= clamp_target(cfg_data_i[TARGET_W-1:0]);
        CFG_RIGHT_TARGET: target_q[1]  <= clamp_target(cfg_data_i[TARGET_W-1:0]);
        default: ;  // unknown index, write dropped
      endcase
    end
  end

  // ---------------------------------------------------------------------------
  // flow control: both registers move when the output slot is free
  // ---------------------------------------------------------------------------
  logic adv;
  logic in_vld_q, out_vld_q;

  assign adv           = !out_vld_q || m_axis_tready;
  assign s_axis_tready = adv;
  assign m_axis_tvalid = out_vld_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_vld_q  <= 1'b0;
      out_vld_q <= 1'b0;
    end else if (adv) begin
      in_vld_q  <= s_axis_tvalid;
      out_vld_q <= in_vld_q;
    end
  end

  // ---------------------------------------------------------------------------
  // input register
  // ---------------------------------------------------------------------------
  logic signed [COUNT_W-1:0] count_q [NUM_WHEELS];

  always_ff @(posedge clk_i) begin
    if (adv && s_axis_tvalid) begin
      count_q[0] <= signed'(s_axis_tdata[COUNT_W-1:0]);
      count_q[1] <= signed'(s_axis_tdata[2*COUNT_W-1:COUNT_W]);
    end
  end

  // ---------------------------------------------------------------------------
  // error and its first and second differences
  // ---------------------------------------------------------------------------
  logic signed [ERR_W-1:0] last_err_q  [NUM_WHEELS];
  logic signed [ERR_W-1:0] older_err_q [NUM_WHEELS];
  logic signed [ERR_W-1:0] err_d       [NUM_WHEELS];
  logic signed [ERR_W-1:0] dif1_d      [NUM_WHEELS];
  logic signed [D2_W-1:0]  dif2_d      [NUM_WHEELS];

  always_comb begin
    for (int w = 0; w < NUM_WHEELS; w++) begin
      err_d[w]  = ERR_W'(target_q[w]) - ERR_W'(count_q[w]);
      dif1_d[w] = err_d[w] - last_err_q[w];
      dif2_d[w] = D2_W'(err_d[w]) - (D2_W'(last_err_q[w]) <<< 1)
                + D2_W'(older_err_q[w]);
    end
  end

  // ---------------------------------------------------------------------------
  // one multiply per term and wheel, gains taken as positive signed
  // ---------------------------------------------------------------------------
  logic signed [GAIN_W:0]   kp_s, ki_s, kd_s;
  logic signed [PROD_W-1:0] p_term [NUM_WHEELS];
  logic signed [PROD_W-1:0] i_term [NUM_WHEELS];
  logic signed [PROD_W-1:0] d_term [NUM_WHEELS];

  assign kp_s = signed'({1'b0, prop_gain_q});
  assign ki_s = signed'({1'b0, integ_gain_q});
  assign kd_s = signed'({1'b0, deriv_gain_q});

  always_comb begin
    for (int w = 0; w < NUM_WHEELS; w++) begin
      p_term[w] = kp_s * dif1_d[w];
      i_term[w] = ki_s * err_d[w];
      d_term[w] = kd_s * dif2_d[w];
    end
  end

  // ---------------------------------------------------------------------------
  // accumulate and saturate to +/- PWM_LIMIT in Q.8
  // ---------------------------------------------------------------------------
  logic signed [ACC_W-1:0] acc_q   [NUM_WHEELS];
  logic signed [ACC_W-1:0] acc_d   [NUM_WHEELS];
  logic signed [SUM_W-1:0] acc_sum [NUM_WHEELS];

  always_comb begin
    for (int w = 0; w < NUM_WHEELS; w++) begin
      acc_sum[w] = SUM_W'(acc_q[w]) + SUM_W'(p_term[w])
                 + SUM_W'(i_term[w]) + SUM_W'(d_term[w]);
      if (acc_sum[w] > SUM_W'(ACC_LIMIT)) begin
        acc_d[w] = ACC_LIMIT;
      end else if (acc_sum[w] < -SUM_W'(ACC_LIMIT)) begin
        acc_d[w] = -ACC_LIMIT;
      end else begin
        acc_d[w] = acc_sum[w][ACC_W-1:0];
      end
    end
  end

  // ---------------------------------------------------------------------------
  // truncate toward zero and steer magnitude to one bridge leg
  // ---------------------------------------------------------------------------
  logic [ACC_W-1:0]  acc_mag [NUM_WHEELS];
  logic [DUTY_W-1:0] mag_duty[NUM_WHEELS];
  logic [DUTY_W-1:0] fwd_d   [NUM_WHEELS];
  logic [DUTY_W-1:0] rev_d   [NUM_WHEELS];
  logic [DUTY_W-1:0] fwd_q   [NUM_WHEELS];
  logic [DUTY_W-1:0] rev_q   [NUM_WHEELS];

  always_comb begin
    for (int w = 0; w < NUM_WHEELS; w++) begin
      // magnitude first, then drop fraction bits: that is truncation toward zero
      acc_mag[w]  = acc_d[w][ACC_W-1] ? ACC_W'(-acc_d[w]) : ACC_W'(acc_d[w]);
      mag_duty[w] = acc_mag[w][GAIN_FRAC_BITS +: DUTY_W];
      fwd_d[w]    = acc_d[w][ACC_W-1] ? '0 : mag_duty[w];
      rev_d[w]    = acc_d[w][ACC_W-1] ? mag_duty[w] : '0;
    end
  end

  // ---------------------------------------------------------------------------
  // wheel state and result register, all loaded by the same item
  // ---------------------------------------------------------------------------
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int w = 0; w < NUM_WHEELS; w++) begin
        last_err_q[w]  <= '0;
        older_err_q[w] <= '0;
        acc_q[w]       <= '0;
      end
    end else if (adv && in_vld_q) begin
      for (int w = 0; w < NUM_WHEELS; w++) begin
        older_err_q[w] <= last_err_q[w];
        last_err_q[w]  <= err_d[w];
      end
      acc_q <= acc_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv && in_vld_q) begin
      fwd_q <= fwd_d;
      rev_q <= rev_d;
    end
  end

  assign m_axis_tdata = {rev_q[1], fwd_q[1], rev_q[0], fwd_q[0]};

  // ---------------------------------------------------------------------------
  // assertions
  // ---------------------------------------------------------------------------
  a_one_leg_only : assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid |-> ((fwd_q[0] == '0) || (rev_q[0] == '0))
                   && ((fwd_q[1] == '0) || (rev_q[1] == '0)))
    else $error("both bridge legs driven on one wheel");

  a_duty_limit : assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid |-> (fwd_q[0] <= DUTY_W'(PWM_LIMIT)) && (rev_q[0] <= DUTY_W'(PWM_LIMIT))
                   && (fwd_q[1] <= DUTY_W'(PWM_LIMIT)) && (rev_q[1] <= DUTY_W'(PWM_LIMIT)))
    else $error("duty above pwm limit");

  a_acc_saturated : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (acc_q[0] <= ACC_LIMIT) && (acc_q[0] >= -ACC_LIMIT)
    && (acc_q[1] <= ACC_LIMIT) && (acc_q[1] >= -ACC_LIMIT))
    else $error("accumulator outside saturation range");

  a_history_shift : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (adv && in_vld_q) |=> (older_err_q[0] == $past(last_err_q[0]))
                       && (older_err_q[1] == $past(last_err_q[1])))
    else $error("error history did not shift");

endmodule

// ----- verif/dipid_drive_checker.sv -----
module dipid_drive_checker
  import dipid_pkg::*;
(
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  cfg_valid_i,
  input  logic                  cfg_ready_i,
  input  logic [CFG_IDX_W-1:0]  cfg_index_i,
  input  logic [CFG_DATA_W-1:0] cfg_data_i,
  input  logic                  tick_valid_i,
  input  logic                  tick_ready_i,
  input  logic [31:0]           tick_data_i,   // left_count[15:0], right_count[31:16]
  input  logic                  duty_valid_i,
  input  logic                  duty_ready_i,
  input  logic [39:0]           duty_data_i,   // left fwd, left rev, right fwd, right rev
  output int                    fail_count_o,
  output int                    results_o,
  output int                    pending_o,
  output int                    limit_hits_o
);

  localparam int REPORT_LIMIT = 10;
  localparam logic [GAIN_W-1:0] PROP_GAIN_RST  = 16'd128;
  localparam logic [GAIN_W-1:0] INTEG_GAIN_RST = 16'd26;
  localparam logic [GAIN_W-1:0] DERIV_GAIN_RST = 16'd0;

  typedef struct {
    logic [DUTY_W-1:0] left_fwd;
    logic [DUTY_W-1:0] left_rev;
    logic [DUTY_W-1:0] right_fwd;
    logic [DUTY_W-1:0] right_rev;
  } duty_set_t;

  logic [GAIN_W-1:0]          kp;
  logic [GAIN_W-1:0]          ki;
  logic [GAIN_W-1:0]          kd;
  logic signed [TARGET_W-1:0] wheel_target [NUM_WHEELS];
  logic signed [ACC_W-1:0]    drive_sum    [NUM_WHEELS];
  logic signed [ERR_W-1:0]    prev_err     [NUM_WHEELS];
  logic signed [ERR_W-1:0]    prev2_err    [NUM_WHEELS];
  duty_set_t                  duty_queue   [$];

  function automatic void note_failure(input string what);
    fail_count_o++;
    if (fail_count_o <= REPORT_LIMIT) begin
      $display("[%0t] mismatch: %s", $time, what);
    end
  endfunction

  // low 11 bits as a signed target, pinned to the target range
  function automatic logic signed [TARGET_W-1:0] saturate_target(
    input logic [CFG_DATA_W-1:0] raw
  );
    int t;
    t = int'(signed'(raw[TARGET_W-1:0]));
    if (t > int'(TARGET_LIMIT)) begin
      t = int'(TARGET_LIMIT);
    end else if (t < -int'(TARGET_LIMIT)) begin
      t = -int'(TARGET_LIMIT);
    end
    return TARGET_W'(t);
  endfunction

  // one velocity-form pid step for a wheel, returns the whole-count drive
  function automatic int wheel_drive(input int w, input logic [COUNT_W-1:0] count);
    longint err;
    longint err1;
    longint err2;
    longint step;
    longint sum;
    longint lim;
    lim  = longint'(PWM_LIMIT) << GAIN_FRAC_BITS;
    err  = longint'(wheel_target[w]) - longint'(signed'(count));
    err1 = prev_err[w];
    err2 = prev2_err[w];
    step = longint'(kp) * (err - err1) + longint'(ki) * err
         + longint'(kd) * (err - 2 * err1 + err2);
    sum  = longint'(drive_sum[w]) + step;
    if (sum > lim) begin
      sum = lim;
    end else if (sum < -lim) begin
      sum = -lim;
    end
    drive_sum[w] = ACC_W'(sum);
    prev2_err[w] = prev_err[w];
    prev_err[w]  = ERR_W'(err);
    // signed division drops the fraction toward zero
    return int'(sum / (longint'(1) << GAIN_FRAC_BITS));
  endfunction

  function automatic void split_drive(input int v, output logic [DUTY_W-1:0] fwd,
                                      output logic [DUTY_W-1:0] rev);
    fwd = (v > 0) ? DUTY_W'(v) : '0;
    rev = (v < 0) ? DUTY_W'(-v) : '0;
  endfunction

  always @(posedge clk_i or negedge rst_ni) begin : watch
    duty_set_t got;
    duty_set_t want;
    duty_set_t fresh;
    if (!rst_ni) begin
      kp = PROP_GAIN_RST;
      ki = INTEG_GAIN_RST;
      kd = DERIV_GAIN_RST;
      for (int w = 0; w < NUM_WHEELS; w++) begin
        wheel_target[w] = '0;
        drive_sum[w]    = '0;
        prev_err[w]     = '0;
        prev2_err[w]    = '0;
      end
      duty_queue.delete();
      fail_count_o = 0;
      results_o    = 0;
      pending_o    = 0;
      limit_hits_o = 0;
    end else begin
      if (cfg_valid_i && cfg_ready_i) begin
        case (cfg_index_i)
          CFG_PROP_GAIN:    kp = cfg_data_i[GAIN_W-1:0];
          CFG_INTEG_GAIN:   ki = cfg_data_i[GAIN_W-1:0];
          CFG_DERIV_GAIN:   kd = cfg_data_i[GAIN_W-1:0];
          CFG_LEFT_TARGET:  wheel_target[0] = saturate_target(cfg_data_i);
          CFG_RIGHT_TARGET: wheel_target[1] = saturate_target(cfg_data_i);
          default: ;
        endcase
      end

      // a result leaving now never belongs to a tick entering at the same edge
      if (duty_valid_i && duty_ready_i) begin
        got.left_fwd  = duty_data_i[DUTY_W-1:0];
        got.left_rev  = duty_data_i[2*DUTY_W-1:DUTY_W];
        got.right_fwd = duty_data_i[3*DUTY_W-1:2*DUTY_W];
        got.right_rev = duty_data_i[4*DUTY_W-1:3*DUTY_W];
        results_o++;
        if (got.left_fwd == PWM_LIMIT || got.left_rev == PWM_LIMIT ||
            got.right_fwd == PWM_LIMIT || got.right_rev == PWM_LIMIT) begin
          limit_hits_o++;
        end
        if (duty_queue.size() == 0) begin
          note_failure($sformatf("duty transfer %h with no tick outstanding", duty_data_i));
        end else begin
          want = duty_queue.pop_front();
          if (got.left_fwd !== want.left_fwd || got.left_rev !== want.left_rev ||
              got.right_fwd !== want.right_fwd || got.right_rev !== want.right_rev) begin
            note_failure($sformatf(
              "result %0d exp L %0d/%0d R %0d/%0d got L %0d/%0d R %0d/%0d",
              results_o, want.left_fwd, want.left_rev, want.right_fwd, want.right_rev,
              got.left_fwd, got.left_rev, got.right_fwd, got.right_rev));
          end
        end
      end

      if (tick_valid_i && tick_ready_i) begin
        split_drive(wheel_drive(0, tick_data_i[COUNT_W-1:0]),
                    fresh.left_fwd, fresh.left_rev);
        split_drive(wheel_drive(1, tick_data_i[2*COUNT_W-1:COUNT_W]),
                    fresh.right_fwd, fresh.right_rev);
        duty_queue.push_back(fresh);
      end
      pending_o = duty_queue.size();
    end
  end

endmodule

// ----- verif/tb_dual_incremental_pid_hbridge_drive.sv -----
module tb_dual_incremental_pid_hbridge_drive;
  import dipid_pkg::*;

  localparam int CLK_PERIOD     = 12;
  localparam int RESET_CYCLES   = 2;
  localparam int IDLE_PCT       = 36;      // chance of an idle cycle on either side
  localparam int PIPE_DRAIN     = 12;      // two-register path plus margin
  localparam int HOLD_CYCLES    = 120;     // long output back-pressure stretch
  localparam int PHASES         = 8;
  localparam int PHASE_TICKS    = 210;
  localparam int TIMEOUT_CYCLES = 400000;
  // first register index that the block does not decode
  localparam logic [CFG_IDX_W-1:0] CFG_FIRST_UNUSED = CFG_IDX_W'(CFG_RIGHT_TARGET + 1);
  localparam logic [CFG_IDX_W-1:0] CFG_LAST_UNUSED  = '1;

  logic                  clk_i         = 1'b0;
  logic                  rst_ni        = 1'b0;

  // register write channel
  logic                  cfg_valid_i   = 1'b0;
  logic                  cfg_ready_o;
  logic [CFG_IDX_W-1:0]  cfg_index_i   = '0;
  logic [CFG_DATA_W-1:0] cfg_data_i    = '0;

  // encoder ticks in
  logic                  s_axis_tvalid = 1'b0;
  logic                  s_axis_tready;
  logic [31:0]           s_axis_tdata  = '0;   // left_count[15:0], right_count[31:16]

  // pwm compare values out
  logic                  m_axis_tvalid;
  logic                  m_axis_tready = 1'b0;
  logic [39:0]           m_axis_tdata;         // left_forward_duty[9:0],
                                               // left_reverse_duty[19:10],
                                               // right_forward_duty[29:20],
                                               // right_reverse_duty[39:30]

  // stimulus control shared between the processes
  bit src_calm     = 1'b0;   // sender never idles while set
  bit sink_calm    = 1'b0;   // receiver always ready while set, unless held
  bit sink_hold    = 1'b0;   // receiver refuses every transfer while set
  bit hold_request = 1'b0;

  int ticks_sent    = 0;
  int settings_used = 0;
  int left_aim      = 0;     // current targets, used to keep counts plausible
  int right_aim     = 0;

  // checker status
  int fail_count;
  int results_seen;
  int pending;
  int limit_hits;

  dual_incremental_pid_hbridge_drive u_top (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .cfg_valid_i   (cfg_valid_i),
    .cfg_ready_o   (cfg_ready_o),
    .cfg_index_i   (cfg_index_i),
    .cfg_data_i    (cfg_data_i),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata)
  );

  dipid_drive_checker u_checker (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .cfg_valid_i  (cfg_valid_i),
    .cfg_ready_i  (cfg_ready_o),
    .cfg_index_i  (cfg_index_i),
    .cfg_data_i   (cfg_data_i),
    .tick_valid_i (s_axis_tvalid),
    .tick_ready_i (s_axis_tready),
    .tick_data_i  (s_axis_tdata),
    .duty_valid_i (m_axis_tvalid),
    .duty_ready_i (m_axis_tready),
    .duty_data_i  (m_axis_tdata),
    .fail_count_o (fail_count),
    .results_o    (results_seen),
    .pending_o    (pending),
    .limit_hits_o (limit_hits)
  );

  initial begin
    forever #(CLK_PERIOD / 2) clk_i = ~clk_i;
  end

  // hard stop in case the block hangs on either handshake
  initial begin
    #(CLK_PERIOD * TIMEOUT_CYCLES);
    $display("timeout: %0d ticks sent, %0d results seen", ticks_sent, results_seen);
    $display("tb_dual_incremental_pid_hbridge_drive NOT OK");
    $finish;
  end

  // receiver: random ready, except during calm or hold stretches
  initial begin
    forever begin
      @(posedge clk_i);
      if (sink_hold) begin
        m_axis_tready <= 1'b0;
      end else if (sink_calm) begin
        m_axis_tready <= 1'b1;
      end else begin
        m_axis_tready <= ($urandom_range(99) >= IDLE_PCT);
      end
    end
  end

  // long output hold, counted here so the sender keeps pushing meanwhile
  initial begin
    forever begin
      wait (hold_request);
      sink_hold = 1'b1;
      repeat (HOLD_CYCLES) @(posedge clk_i);
      sink_hold    = 1'b0;
      hold_request = 1'b0;
    end
  end

  // one tick transfer; tvalid stays high afterwards so back-to-back ticks need
  // no extra edge; an idle cycle in the next call, or drain(), lowers it
  task automatic send_tick(input logic [COUNT_W-1:0] left, input logic [COUNT_W-1:0] right);
    while (!src_calm && $urandom_range(99) < IDLE_PCT) begin
      s_axis_tvalid <= 1'b0;
      @(posedge clk_i);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tdata  <= {right, left};
    do @(posedge clk_i); while (!s_axis_tready);
    ticks_sent++;
  endtask

  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DATA_W-1:0] data);
    cfg_valid_i <= 1'b1;
    cfg_index_i <= idx;
    cfg_data_i  <= data;
    do @(posedge clk_i); while (!cfg_ready_o);
    cfg_valid_i <= 1'b0;
    @(posedge clk_i);
  endtask

  task automatic set_targets(input logic [CFG_DATA_W-1:0] left_raw,
                             input logic [CFG_DATA_W-1:0] right_raw);
    write_reg(CFG_LEFT_TARGET, left_raw);
    write_reg(CFG_RIGHT_TARGET, right_raw);
    left_aim  = int'(signed'(left_raw[TARGET_W-1:0]));
    right_aim = int'(signed'(right_raw[TARGET_W-1:0]));
  endtask

  // block idle: every tick answered and the pipeline flushed
  task automatic drain();
    s_axis_tvalid <= 1'b0;
    while (results_seen != ticks_sent) @(posedge clk_i);
    repeat (PIPE_DRAIN) @(posedge clk_i);
  endtask

  // mostly counts close to the target so the loop stays out of saturation,
  // some larger disturbances and some fully random counts
  function automatic logic [COUNT_W-1:0] pick_count(input int aim);
    int roll;
    roll = $urandom_range(99);
    if (roll < 60) begin
      return COUNT_W'(aim + int'($urandom_range(128)) - 64);
    end else if (roll < 85) begin
      return COUNT_W'(aim + int'($urandom_range(4000)) - 2000);
    end
    return COUNT_W'($urandom);
  endfunction

  function automatic logic [CFG_DATA_W-1:0] any_target();
    return CFG_DATA_W'(int'($urandom_range(2 * TARGET_LIMIT)) - int'(TARGET_LIMIT));
  endfunction

  initial begin
    repeat (RESET_CYCLES) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // reset tuning, zero targets: the first tick has zero error, zero drive
    settings_used++;
    send_tick(16'sd0, 16'sd0);
    send_tick(16'sd32767, -16'sd32768);
    send_tick(-16'sd32768, 16'sd32767);
    send_tick(-16'sd1, 16'sd1);
    send_tick(16'sd1, -16'sd1);
    send_tick(16'h5555, 16'hAAAA);
    send_tick(16'sd0, 16'sd0);

    // full-scale gains and out-of-range targets that must clip to the limit,
    // the accumulator pins at both rails
    drain();
    settings_used++;
    write_reg(CFG_PROP_GAIN, 16'hFFFF);
    write_reg(CFG_INTEG_GAIN, 16'hFFFF);
    write_reg(CFG_DERIV_GAIN, 16'hFFFF);
    set_targets(16'hFBFF, 16'h0400);
    send_tick(16'sd0, 16'sd0);
    send_tick(16'sd0, 16'sd0);
    send_tick(16'sd32767, -16'sd32768);
    send_tick(-16'sd32768, 16'sd32767);
    send_tick(16'sd0, 16'sd0);
    send_tick(16'sd1000, -16'sd1000);

    // zero gains hold the output; writes to undecoded indexes change nothing
    drain();
    settings_used++;
    write_reg(CFG_PROP_GAIN, 16'h0000);
    write_reg(CFG_INTEG_GAIN, 16'h0000);
    write_reg(CFG_DERIV_GAIN, 16'h0000);
    for (int i = CFG_FIRST_UNUSED; i <= CFG_LAST_UNUSED; i++) begin
      write_reg(CFG_IDX_W'(i), 16'hFFFF);
    end
    send_tick(16'sd0, 16'sd0);
    send_tick(16'sd5, -16'sd5);

    // pure proportional at unity, targets back to zero
    drain();
    settings_used++;
    write_reg(CFG_PROP_GAIN, 16'h0100);
    set_targets(16'h0000, 16'h0000);
    send_tick(16'sd300, -16'sd300);
    send_tick(16'sd0, 16'sd0);
    send_tick(-16'sd700, 16'sd700);
    send_tick(16'sd0, 16'sd0);

    // random phases, each with its own tuning
    for (int p = 0; p < PHASES; p++) begin
      drain();
      settings_used++;
      case (p % 4)
        0: begin  // nominal tuning, light derivative
          write_reg(CFG_PROP_GAIN, 16'd128);
          write_reg(CFG_INTEG_GAIN, 16'd26);
          write_reg(CFG_DERIV_GAIN, CFG_DATA_W'($urandom_range(64)));
          set_targets(any_target(), any_target());
        end
        1: begin  // small gains, loop mostly linear
          write_reg(CFG_PROP_GAIN, CFG_DATA_W'($urandom_range(512)));
          write_reg(CFG_INTEG_GAIN, CFG_DATA_W'($urandom_range(512)));
          write_reg(CFG_DERIV_GAIN, CFG_DATA_W'($urandom_range(512)));
          set_targets(any_target(), any_target());
        end
        2: begin  // largest gains and targets at the limits
          write_reg(CFG_PROP_GAIN, 16'hFFFF);
          write_reg(CFG_INTEG_GAIN, 16'hFFFF);
          write_reg(CFG_DERIV_GAIN, 16'hFFFF);
          set_targets(CFG_DATA_W'(TARGET_LIMIT), CFG_DATA_W'(-int'(TARGET_LIMIT)));
        end
        default: begin  // raw random words, targets may need clipping
          write_reg(CFG_PROP_GAIN, CFG_DATA_W'($urandom));
          write_reg(CFG_INTEG_GAIN, CFG_DATA_W'($urandom));
          write_reg(CFG_DERIV_GAIN, CFG_DATA_W'($urandom));
          set_targets(CFG_DATA_W'($urandom), CFG_DATA_W'($urandom));
        end
      endcase
      if ($urandom_range(3) == 0) begin
        write_reg(CFG_IDX_W'($urandom_range(CFG_LAST_UNUSED, CFG_FIRST_UNUSED)),
                  CFG_DATA_W'($urandom));
      end

      // phase 2 runs with no idling at all; phase 5 stalls the output for a
      // long stretch while ticks keep coming, so the pipeline backs up
      src_calm  = (p == 2) || (p == 5);
      sink_calm = (p == 2);
      if (p == 5) begin
        hold_request = 1'b1;
      end
      for (int n = 0; n < PHASE_TICKS; n++) begin
        send_tick(pick_count(left_aim), pick_count(right_aim));
      end
    end
    src_calm  = 1'b0;
    sink_calm = 1'b0;

    drain();
    $display("run covered %0d encoder ticks under %0d controller settings, %0d results",
             ticks_sent, settings_used, results_seen);
    $display("%0d results sat at the pwm limit; one %0d-cycle output stall backed up the input",
             limit_hits, HOLD_CYCLES);
    if (fail_count == 0 && pending == 0) begin
      $display("tb_dual_incremental_pid_hbridge_drive OK");
    end else begin
      $display("%0d mismatches, %0d results missing", fail_count, pending);
      $display("tb_dual_incremental_pid_hbridge_drive NOT OK");
    end
    $finish;
  end

endmodule

// ----- files.f -----
design/dipid_pkg.sv
design/dual_incremental_pid_hbridge_drive.sv
verif/dipid_drive_checker.sv
verif/tb_dual_incremental_pid_hbridge_drive.sv
